[hdl/gtl_pkg.sv]
// Shared types, character codes and limits for the grammar token lexer.
package gtl_pkg;

  localparam int unsigned MAX_SYMBOL_LEN = 64;
  localparam int unsigned TEXT_BYTES     = 16384;
  localparam int unsigned POS_W          = 14;
  localparam int unsigned RUN_W          = 7;
  localparam int unsigned LINE_W         = 16;
  localparam int unsigned LEN_W          = 6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam logic [RUN_W-1:0]  RUN_MAX  = RUN_W'(MAX_SYMBOL_LEN);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(TEXT_BYTES - 1);
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_NONTERM = 3'd2,
    MODE_QUOTE1  = 3'd3,
    MODE_BODY    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NONTERM = 3'd0,
    KIND_TERM    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_COLON   = 3'd3,
    KIND_PIPE    = 3'd4,
    KIND_SEMI    = 3'd5,
    KIND_END     = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NONTERM  = 3'd1,
    ERR_TERM     = 3'd2,
    ERR_BAD_CHAR = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    err_t              err;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic [LINE_W-1:0] line;
  } result_t;

endpackage

[hdl/gtl_lexer.sv]
// Lexer state registers and the per-byte scan logic.
module gtl_lexer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           ch,
  output logic                 halted,
  output gtl_pkg::result_t     res
);

  gtl_pkg::mode_t                 mode, mode_next;
  logic                           quote_single, quote_single_next;
  logic [gtl_pkg::POS_W-1:0]      pos, pos_next;
  logic [gtl_pkg::POS_W-1:0]      start, start_next;
  logic [gtl_pkg::RUN_W-1:0]      run, run_next;
  logic [gtl_pkg::LINE_W-1:0]     line, line_next;
  logic                           halted_next;

  logic [gtl_pkg::RUN_W-1:0]      run_inc;
  logic [gtl_pkg::LINE_W-1:0]     line_inc;
  logic [7:0]                     quote_ch;

  assign run_inc  = (run < gtl_pkg::RUN_MAX) ? run + 1'b1 : run;
  assign line_inc = (line < gtl_pkg::LINE_MAX) ? line + 1'b1 : line;
  assign quote_ch = quote_single ? gtl_pkg::CH_SQUOTE : gtl_pkg::CH_DQUOTE;

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    start_next        = start;
    run_next          = run;
    line_next         = line;
    halted_next       = halted;
    pos_next          = (pos == gtl_pkg::POS_LAST) ? '0 : pos + 1'b1;
    unique case (mode) inside
      gtl_pkg::MODE_COMMENT: begin
        if (ch == gtl_pkg::CH_NUL) begin
          halted_next = 1'b1;
        end else if (ch == gtl_pkg::CH_NL) begin
          line_next = line_inc;
          mode_next = gtl_pkg::MODE_IDLE;
        end
      end
      gtl_pkg::MODE_NONTERM: begin
        run_next = run_inc;
        if (ch == gtl_pkg::CH_GT) begin
          mode_next = gtl_pkg::MODE_IDLE;
          if (run_inc >= gtl_pkg::RUN_MAX) begin
            halted_next = 1'b1;
          end
        end else if (ch == gtl_pkg::CH_NUL || ch == gtl_pkg::CH_NL) begin
          halted_next = 1'b1;
        end
      end
      gtl_pkg::MODE_QUOTE1, gtl_pkg::MODE_BODY: begin
        if (ch == gtl_pkg::CH_NUL || ch == gtl_pkg::CH_NL) begin
          halted_next = 1'b1;
        end else begin
          run_next = run_inc;
          if (ch == quote_ch) begin
            mode_next = gtl_pkg::MODE_IDLE;
            if (run_inc >= gtl_pkg::RUN_MAX) begin
              halted_next = 1'b1;
            end
          end else begin
            mode_next = gtl_pkg::MODE_BODY;
          end
        end
      end
      default: begin
        mode_next = gtl_pkg::MODE_IDLE;
        case (ch) inside
          gtl_pkg::CH_SPACE, gtl_pkg::CH_TAB: begin
          end
          gtl_pkg::CH_NL: begin
            line_next = line_inc;
          end
          gtl_pkg::CH_HASH: begin
            mode_next = gtl_pkg::MODE_COMMENT;
          end
          gtl_pkg::CH_LT: begin
            start_next = pos;
            run_next   = gtl_pkg::RUN_W'(1);
            mode_next  = gtl_pkg::MODE_NONTERM;
          end
          gtl_pkg::CH_DQUOTE, gtl_pkg::CH_SQUOTE: begin
            start_next        = pos;
            run_next          = gtl_pkg::RUN_W'(1);
            quote_single_next = (ch == gtl_pkg::CH_SQUOTE);
            mode_next         = gtl_pkg::MODE_QUOTE1;
          end
          gtl_pkg::CH_COLON, gtl_pkg::CH_PIPE, gtl_pkg::CH_SEMI: begin
          end
          default: begin
            halted_next = 1'b1;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    res.valid  = 1'b0;
    res.kind   = gtl_pkg::KIND_END;
    res.err    = gtl_pkg::ERR_NONE;
    res.start  = pos;
    res.length = '0;
    res.line   = line;
    unique case (mode) inside
      gtl_pkg::MODE_COMMENT: begin
        if (ch == gtl_pkg::CH_NUL) begin
          res.valid = 1'b1;
        end
      end
      gtl_pkg::MODE_NONTERM: begin
        res.start = start;
        if (ch == gtl_pkg::CH_GT) begin
          res.valid = 1'b1;
          if (run_inc >= gtl_pkg::RUN_MAX) begin
            res.kind = gtl_pkg::KIND_ERROR;
            res.err  = gtl_pkg::ERR_TOO_LONG;
          end else begin
            res.kind   = gtl_pkg::KIND_NONTERM;
            res.length = run_inc[gtl_pkg::LEN_W-1:0];
          end
        end else if (ch == gtl_pkg::CH_NUL || ch == gtl_pkg::CH_NL) begin
          res.valid = 1'b1;
          res.kind  = gtl_pkg::KIND_ERROR;
          res.err   = gtl_pkg::ERR_NONTERM;
        end
      end
      gtl_pkg::MODE_QUOTE1, gtl_pkg::MODE_BODY: begin
        res.start = start;
        if (ch == gtl_pkg::CH_NUL || ch == gtl_pkg::CH_NL) begin
          res.valid = 1'b1;
          res.kind  = gtl_pkg::KIND_ERROR;
          res.err   = gtl_pkg::ERR_TERM;
        end else if (ch == quote_ch) begin
          res.valid = 1'b1;
          if (run_inc >= gtl_pkg::RUN_MAX) begin
            res.kind = gtl_pkg::KIND_ERROR;
            res.err  = gtl_pkg::ERR_TOO_LONG;
          end else begin
            res.kind   = gtl_pkg::kind_t'((run_inc == gtl_pkg::RUN_W'(2)) ?
                                          gtl_pkg::KIND_EMPTY : gtl_pkg::KIND_TERM);
            res.length = run_inc[gtl_pkg::LEN_W-1:0];
          end
        end
      end
      default: begin
        case (ch) inside
          gtl_pkg::CH_SPACE, gtl_pkg::CH_TAB, gtl_pkg::CH_NL, gtl_pkg::CH_HASH,
          gtl_pkg::CH_LT, gtl_pkg::CH_DQUOTE, gtl_pkg::CH_SQUOTE: begin
          end
          gtl_pkg::CH_COLON: begin
            res.valid  = 1'b1;
            res.kind   = gtl_pkg::KIND_COLON;
            res.length = gtl_pkg::LEN_W'(1);
          end
          gtl_pkg::CH_PIPE: begin
            res.valid  = 1'b1;
            res.kind   = gtl_pkg::KIND_PIPE;
            res.length = gtl_pkg::LEN_W'(1);
          end
          gtl_pkg::CH_SEMI: begin
            res.valid  = 1'b1;
            res.kind   = gtl_pkg::KIND_SEMI;
            res.length = gtl_pkg::LEN_W'(1);
          end
          gtl_pkg::CH_NUL: begin
            res.valid = 1'b1;
          end
          default: begin
            res.valid = 1'b1;
            res.kind  = gtl_pkg::KIND_ERROR;
            res.err   = gtl_pkg::ERR_BAD_CHAR;
          end
        endcase
      end
    endcase
    if (halted) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= gtl_pkg::MODE_IDLE;
      quote_single <= 1'b0;
      pos          <= '0;
      start        <= '0;
      run          <= '0;
      line         <= gtl_pkg::LINE_W'(1);
      halted       <= 1'b0;
    end else if (advance && !halted) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      pos          <= pos_next;
      start        <= start_next;
      run          <= run_next;
      line         <= line_next;
      halted       <= halted_next;
    end
  end

endmodule

[hdl/gtl_out_reg.sv]
// Result register driving the output channel.
module gtl_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gtl_pkg::result_t     res,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 space,
  output gtl_pkg::result_t     held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load && res.valid) begin
      held <= res;
    end
  end

endmodule

[hdl/grammar_token_lexer.sv]
// Top level of the grammar token lexer: input register, scan logic, result register.
//
//   channel | signals                       | direction
//   in      | in_valid, in_ready, ch        | byte stream in
//   out     | out_valid, out_ready, token_* | one token per transaction
//
// One byte per cycle unless the output stalls; input and result are registered.
// The input register advances into the scan logic whenever the result register
// is empty or being drained, so a stalled output stalls the input by one slot.
// Reset clears the scan state to between tokens, line one, offset zero.
// After an end or error token every further byte is taken and dropped.
module grammar_token_lexer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    token_kind,
  output logic [2:0]                    error_code,
  output logic [gtl_pkg::POS_W-1:0]     token_start,
  output logic [gtl_pkg::LEN_W-1:0]     token_length,
  output logic [gtl_pkg::LINE_W-1:0]    line_number
);

  logic             s1_valid;
  logic [7:0]       s1_ch;
  logic             space;
  logic             advance;
  logic             halted;
  gtl_pkg::result_t res;
  gtl_pkg::result_t held;

  assign advance  = s1_valid && space;
  assign in_ready = !s1_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch <= ch;
    end
  end

  gtl_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ch      (s1_ch),
    .halted  (halted),
    .res     (res)
  );

  gtl_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .space     (space),
    .held      (held)
  );

  assign token_kind   = held.kind;
  assign error_code   = held.err;
  assign token_start  = held.start;
  assign token_length = held.length;
  assign line_number  = held.line;

`ifndef SYNTHESIS
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == gtl_pkg::KIND_ERROR |->
      error_code != gtl_pkg::ERR_NONE && token_length == '0)
    else $error("error token with bad code or length");
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != gtl_pkg::KIND_ERROR |-> error_code == gtl_pkg::ERR_NONE)
    else $error("non-error token carries an error code");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res.valid)
    else $error("result produced while halted");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != '0)
    else $error("line number zero");
`endif

endmodule

[dv/grammar_token_checker.sv]
`timescale 1ns / 100ps
// Token checker for the grammar token lexer: predicts tokens from accepted bytes and compares.
module grammar_token_checker
  import gtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        ch,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        token_kind,
  input  logic [2:0]        error_code,
  input  logic [POS_W-1:0]  token_start,
  input  logic [LEN_W-1:0]  token_length,
  input  logic [LINE_W-1:0] line_number,
  output int                fail_count,
  output int                pending
);

  mode_t             scan_mode = MODE_IDLE;
  logic              quote_single = 1'b0;
  logic [POS_W-1:0]  byte_pos = '0;
  logic [POS_W-1:0]  tok_start = '0;
  logic [RUN_W-1:0]  run_len = '0;
  logic [LINE_W-1:0] line_cnt = LINE_W'(1);
  logic              halted = 1'b0;

  result_t expected_tokens[$];
  result_t predicted;
  result_t oldest;
  int      mismatches = 0;

  function automatic void bump_run();
    if (run_len < RUN_MAX) run_len = run_len + 1'b1;
  endfunction

  function automatic void bump_line();
    if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic result_t make_token(kind_t k, err_t e, logic [POS_W-1:0] s,
                                         logic [LEN_W-1:0] n);
    result_t r;
    r.valid  = 1'b1;
    r.kind   = k;
    r.err    = e;
    r.start  = s;
    r.length = n;
    r.line   = line_cnt;
    return r;
  endfunction

  function automatic result_t lex_predict(input logic [7:0] c);
    result_t          r;
    logic [POS_W-1:0] at;
    logic [7:0]       q;
    r = '0;
    if (halted) return r;
    at = byte_pos;
    q  = quote_single ? CH_SQUOTE : CH_DQUOTE;
    case (scan_mode)
      MODE_COMMENT: begin
        if (c == CH_NUL) begin
          halted = 1'b1;
          r = make_token(KIND_END, ERR_NONE, at, '0);
        end else if (c == CH_NL) begin
          bump_line();
          scan_mode = MODE_IDLE;
        end
      end
      MODE_NONTERM: begin
        bump_run();
        if (c == CH_GT) begin
          scan_mode = MODE_IDLE;
          if (run_len >= RUN_MAX) begin
            halted = 1'b1;
            r = make_token(KIND_ERROR, ERR_TOO_LONG, tok_start, '0);
          end else begin
            r = make_token(KIND_NONTERM, ERR_NONE, tok_start, run_len[LEN_W-1:0]);
          end
        end else if (c == CH_NUL || c == CH_NL) begin
          halted = 1'b1;
          r = make_token(KIND_ERROR, ERR_NONTERM, tok_start, '0);
        end
      end
      MODE_QUOTE1, MODE_BODY: begin
        if (c == CH_NUL || c == CH_NL) begin
          halted = 1'b1;
          r = make_token(KIND_ERROR, ERR_TERM, tok_start, '0);
        end else begin
          bump_run();
          if (c == q) begin
            scan_mode = MODE_IDLE;
            if (run_len >= RUN_MAX) begin
              halted = 1'b1;
              r = make_token(KIND_ERROR, ERR_TOO_LONG, tok_start, '0);
            end else begin
              r = make_token(kind_t'((run_len == 2) ? KIND_EMPTY : KIND_TERM), ERR_NONE,
                             tok_start, run_len[LEN_W-1:0]);
            end
          end else begin
            scan_mode = MODE_BODY;
          end
        end
      end
      default: begin
        scan_mode = MODE_IDLE;
        case (c)
          CH_SPACE, CH_TAB: begin
          end
          CH_NL: bump_line();
          CH_HASH: scan_mode = MODE_COMMENT;
          CH_LT: begin
            tok_start = at;
            run_len   = RUN_W'(1);
            scan_mode = MODE_NONTERM;
          end
          CH_DQUOTE, CH_SQUOTE: begin
            tok_start    = at;
            run_len      = RUN_W'(1);
            quote_single = (c == CH_SQUOTE);
            scan_mode    = MODE_QUOTE1;
          end
          CH_COLON: r = make_token(KIND_COLON, ERR_NONE, at, LEN_W'(1));
          CH_PIPE:  r = make_token(KIND_PIPE, ERR_NONE, at, LEN_W'(1));
          CH_SEMI:  r = make_token(KIND_SEMI, ERR_NONE, at, LEN_W'(1));
          CH_NUL: begin
            halted = 1'b1;
            r = make_token(KIND_END, ERR_NONE, at, '0);
          end
          default: begin
            halted = 1'b1;
            r = make_token(KIND_ERROR, ERR_BAD_CHAR, at, '0);
          end
        endcase
      end
    endcase
    byte_pos = (at == POS_LAST) ? '0 : at + 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_mode    = MODE_IDLE;
      quote_single = 1'b0;
      byte_pos     = '0;
      tok_start    = '0;
      run_len      = '0;
      line_cnt     = LINE_W'(1);
      halted       = 1'b0;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted = lex_predict(ch);
        if (predicted.valid) expected_tokens.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token transaction with nothing expected: kind %0d start %0d",
                 token_kind, token_start);
          mismatches++;
        end else begin
          oldest = expected_tokens.pop_front();
          check_field("token_kind", oldest.kind, token_kind);
          check_field("error_code", oldest.err, error_code);
          check_field("token_start", oldest.start, token_start);
          check_field("token_length", oldest.length, token_length);
          check_field("line_number", oldest.line, line_number);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_tokens.size();
  end

endmodule

[dv/tb_grammar_token_lexer.sv]
`timescale 1ns / 100ps
// Testbench top for the grammar token lexer: grammar text stimulus, stalls and verdict.
module tb_grammar_token_lexer;
  import gtl_pkg::*;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        ch = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        token_kind;
  logic [2:0]        error_code;
  logic [POS_W-1:0]  token_start;
  logic [LEN_W-1:0]  token_length;
  logic [LINE_W-1:0] line_number;

  int fail_count;
  int pending;
  int snd_idle = 38;
  int rcv_idle = 65;
  int bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  grammar_token_lexer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .error_code   (error_code),
    .token_start  (token_start),
    .token_length (token_length),
    .line_number  (line_number)
  );

  grammar_token_checker token_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .error_code   (error_code),
    .token_start  (token_start),
    .token_length (token_length),
    .line_number  (line_number),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] body_byte(input logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == stop || b == CH_NL);
    return b;
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b inside {CH_TAB, CH_NL, CH_SPACE, CH_DQUOTE, CH_HASH, CH_SQUOTE,
                     CH_COLON, CH_SEMI, CH_LT, CH_PIPE});
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 61;
    if (r < 12) return $urandom_range(9, 61);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_symbol(input logic [7:0] open_ch, input logic [7:0] close_ch,
                             input int body_len);
    send_byte(open_ch);
    repeat (body_len) send_byte(body_byte(close_ch));
    send_byte(close_ch);
  endtask

  task automatic send_gap();
    case ($urandom_range(3))
      0: send_byte(CH_SPACE);
      1: send_byte(CH_TAB);
      2: send_byte(CH_NL);
      default: begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 12)) send_byte(body_byte(CH_NL));
        send_byte(CH_NL);
      end
    endcase
  endtask

  task automatic send_token();
    int r;
    logic [7:0] q;
    r = $urandom_range(99);
    q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    if (r < 30) send_symbol(CH_LT, CH_GT, pick_len());
    else if (r < 50) send_symbol(CH_DQUOTE, CH_DQUOTE, pick_len());
    else if (r < 65) send_symbol(CH_SQUOTE, CH_SQUOTE, pick_len());
    else if (r < 70) send_symbol(q, q, 0);
    else if (r < 80) send_byte(CH_COLON);
    else if (r < 90) send_byte(CH_PIPE);
    else send_byte(CH_SEMI);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int upto);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    while (bytes_sent < upto) begin
      if ($urandom_range(1)) send_gap();
      send_token();
    end
    wait_for_results();
  endtask

  task automatic send_terminal_event();
    logic [7:0] q;
    logic [7:0] stop;
    q    = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    stop = $urandom_range(1) ? CH_NL : CH_NUL;
    case ($urandom_range(6))
      0: send_byte(CH_NUL);
      1: begin
        send_text("# tail");
        send_byte(CH_NUL);
      end
      2: begin
        send_text("<ab");
        send_byte(stop);
      end
      3: begin
        send_byte(q);
        repeat ($urandom_range(0, 3)) send_byte(body_byte(q));
        send_byte(stop);
      end
      4: send_byte(bad_byte());
      5: begin
        if ($urandom_range(1)) send_symbol(CH_LT, CH_GT, $urandom_range(62, 80));
        else send_symbol(q, q, $urandom_range(62, 80));
      end
      default: begin
        send_byte(CH_LT);
        repeat (70) send_byte(body_byte(CH_GT));
        send_byte(stop);
      end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_text("<a>:'x'|\"\"'';#c\n\t <>\"'\"");
    send_byte(CH_SPACE);

    run_phase(38, 65, 650);
    run_phase(65, 38, 1300);
    run_phase(0, 0, 1900);

    send_symbol(CH_LT, CH_GT, 6);
    send_text(":'q'|;");

    send_terminal_event();
    repeat (6) send_byte(8'($urandom_range(255)));

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gtl_pkg.sv
hdl/gtl_lexer.sv
hdl/gtl_out_reg.sv
hdl/grammar_token_lexer.sv
dv/grammar_token_checker.sv
dv/tb_grammar_token_lexer.sv
